// ===== rtl/msa_pkg.sv =====
// Shared types, codes and constants for the motion session statistics block.
// No dependencies; imported by the controller, the datapath and the top level.
package msa_pkg;

	localparam int SUM_WIDTH = 48;
	localparam int CNT_W     = 6;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_STOP   = 2'd2;

	localparam logic [1:0] PH_NEUTRAL  = 2'd0;
	localparam logic [1:0] PH_SEEK_MAX = 2'd1;
	localparam logic [1:0] PH_SEEK_MIN = 2'd2;

	localparam logic [1:0] CFG_JERK  = 2'd0;
	localparam logic [1:0] CFG_HYST  = 2'd1;
	localparam logic [1:0] CFG_TOL   = 2'd2;
	localparam logic [1:0] CFG_SPEED = 2'd3;

	localparam logic [23:0] JERK_RST  = 24'd8000;
	localparam logic [14:0] HYST_RST  = 15'd640;
	localparam logic [14:0] TOL_RST   = 15'd192;
	localparam logic [15:0] SPEED_RST = 16'd160;

	typedef struct packed {
		logic       capture;
		logic       sq_acc;
		logic       sq_first;
		logic [1:0] sq_sel;
		logic       root_init;
		logic       root_step;
		logic       mul_lo;
		logic       mul_hi;
		logic       update;
		logic       div_init;
		logic       div_step;
		logic       out_load;
	} msa_cmd_t;

endpackage

// ===== rtl/msa_ctrl.sv =====
// Sequencer for the statistics datapath: handshakes and step commands.
// Depends on msa_pkg.
module msa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output msa_pkg::msa_cmd_t cmd
);
	import msa_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ    = 4'd1;
	localparam logic [3:0] ST_RINIT = 4'd2;
	localparam logic [3:0] ST_ROOT  = 4'd3;
	localparam logic [3:0] ST_MUL0  = 4'd4;
	localparam logic [3:0] ST_MUL1  = 4'd5;
	localparam logic [3:0] ST_UPD   = 4'd6;
	localparam logic [3:0] ST_DINIT = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]       state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             out_valid_q;
	logic             can_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		cnt_n   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_SQ;
					cnt_n       = '0;
				end
			end
			ST_SQ: begin
				cmd.sq_acc   = 1'b1;
				cmd.sq_first = (cnt_q == '0);
				cmd.sq_sel   = cnt_q[1:0];
				cnt_n        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(2)) state_n = ST_RINIT;
			end
			ST_RINIT: begin
				cmd.root_init = 1'b1;
				cnt_n         = '0;
				state_n       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_n         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(15)) state_n = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_lo = 1'b1;
				state_n    = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_hi = 1'b1;
				state_n    = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_n    = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_n        = '0;
				state_n      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_n        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_WIDTH - 1)) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (can_load) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/msa_dp.sv =====
// Datapath: session state, config registers, square root, divider, result register.
// Depends on msa_pkg; driven by msa_ctrl commands.
module msa_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  msa_pkg::msa_cmd_t cmd,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	input  logic [1:0]        kind,
	input  logic [31:0]       timestamp_ms,
	input  logic              sample_fresh,
	input  logic [14:0]       roll_angle,
	input  logic [15:0]       rate_x,
	input  logic [15:0]       rate_y,
	input  logic [15:0]       rate_z,
	output logic              session_on,
	output logic              sample_taken,
	output logic [14:0]       angle_min,
	output logic [14:0]       angle_max,
	output logic [14:0]       amplitude,
	output logic [15:0]       mean_speed,
	output logic [9:0]        smoothness_tenths,
	output logic [15:0]       flexion_total,
	output logic [15:0]       tremor_total,
	output logic [31:0]       holding_ms
);
	import msa_pkg::*;

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	// config
	logic [23:0] jerk_q;
	logic [14:0] hyst_q, tol_q;
	logic [15:0] slim_q;

	// captured item
	logic [1:0]         kind_q;
	logic [31:0]        ts_q;
	logic               fresh_q;
	logic signed [14:0] ang_q;
	logic signed [15:0] rx_q, ry_q, rz_q;

	// session state
	logic                 active_q, seen_q;
	logic [31:0]          last_q, total_q, hold_q;
	logic signed [14:0]   min_q, max_q, ext_q;
	logic [SUM_WIDTH-1:0] sum_q;
	logic [15:0]          prev_q, spike_q, flex_q;
	logic [1:0]           phase_q;

	// work registers
	logic [31:0]          acc_q, rad_q;
	logic [16:0]          rem_q;
	logic [15:0]          root_q;
	logic [39:0]          plo_q;
	logic [55:0]          prod_q;
	logic                 taken_q;
	logic [SUM_WIDTH-1:0] divq_q;
	logic [31:0]          drem_q;

	// squares
	logic signed [15:0] rsel;
	logic signed [31:0] sq;
	always_comb begin
		case (cmd.sq_sel)
			2'd0:    rsel = rx_q;
			2'd1:    rsel = ry_q;
			default: rsel = rz_q;
		endcase
		sq = rsel * rsel;
	end

	// root step
	logic [18:0] r_sh, r_trial, r_diff;
	logic        r_ge;
	assign r_sh    = {rem_q, rad_q[31:30]};
	assign r_trial = {1'b0, root_q, 2'b01};
	assign r_ge    = (r_sh >= r_trial);
	assign r_diff  = r_sh - r_trial;

	// divider step
	logic [32:0] d_sh, d_diff;
	logic        d_ge;
	assign d_sh   = {drem_q, divq_q[SUM_WIDTH-1]};
	assign d_ge   = (d_sh >= {1'b0, total_q});
	assign d_diff = d_sh - {1'b0, total_q};

	// upper half of the threshold product, kept at full width
	logic [39:0] phi;
	assign phi = 40'(jerk_q) * 40'(dt[31:16]);

	// sample update
	logic [31:0]          dt;
	logic                 take;
	logic signed [16:0]   ang_x, ext_x, hyst_x, diff;
	logic [16:0]          diff_abs;
	logic signed [14:0]   min_n, max_n, ext_n;
	logic [1:0]           phase_n;
	logic [15:0]          flex_n, spike_n, dv;
	logic [SUM_WIDTH:0]   sum_add;
	logic [SUM_WIDTH-1:0] sum_n;
	logic [31:0]          total_n, hold_n;
	logic [32:0]          hold_add;
	logic [25:0]          dvk;
	logic                 flex_hit;

	assign dt   = ts_q - last_q;
	assign take = (kind_q == KIND_SAMPLE) && active_q && fresh_q && (dt != 32'd0);

	always_comb begin
		ang_x  = {{2{ang_q[14]}}, ang_q};
		ext_x  = {{2{ext_q[14]}}, ext_q};
		hyst_x = {2'b00, hyst_q};
		min_n  = (!seen_q || ang_q < min_q) ? ang_q : min_q;
		max_n  = (!seen_q || ang_q > max_q) ? ang_q : max_q;

		sum_add = {1'b0, sum_q} + {{(SUM_WIDTH - 15){1'b0}}, root_q};
		if (total_q == '1) begin
			sum_n   = sum_q;
			total_n = total_q;
		end else begin
			sum_n   = sum_add[SUM_WIDTH] ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
			total_n = total_q + 32'd1;
		end

		dv      = (root_q >= prev_q) ? root_q - prev_q : prev_q - root_q;
		dvk     = {10'd0, dv} * 26'd1000;
		spike_n = spike_q;
		if ({30'd0, dvk} > prod_q && spike_q != 16'hFFFF) spike_n = spike_q + 16'd1;

		ext_n    = ext_q;
		phase_n  = phase_q;
		flex_hit = 1'b0;
		case (phase_q)
			PH_SEEK_MAX: begin
				if (ang_q > ext_q) ext_n = ang_q;
				else if (ang_x < ext_x - hyst_x) begin
					flex_hit = 1'b1;
					ext_n    = ang_q;
					phase_n  = PH_SEEK_MIN;
				end
			end
			PH_SEEK_MIN: begin
				if (ang_q < ext_q) ext_n = ang_q;
				else if (ang_x > ext_x + hyst_x) begin
					flex_hit = 1'b1;
					ext_n    = ang_q;
					phase_n  = PH_SEEK_MAX;
				end
			end
			default: begin
				ext_n   = ang_q;
				phase_n = PH_SEEK_MAX;
			end
		endcase
		flex_n = (flex_hit && flex_q != 16'hFFFF) ? flex_q + 16'd1 : flex_q;

		diff     = ang_x - {{2{ext_n[14]}}, ext_n};
		diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
		hold_add = {1'b0, hold_q} + {1'b0, dt};
		hold_n   = hold_q;
		if (diff_abs <= {2'b00, tol_q} && root_q <= slim_q)
			hold_n = hold_add[32] ? 32'hFFFF_FFFF : hold_add[31:0];
	end

	// result formatting
	logic signed [14:0] mn, mx;
	logic [19:0]        s15;
	assign mn  = seen_q ? min_q : 15'sd0;
	assign mx  = seen_q ? max_q : 15'sd0;
	assign s15 = {4'd0, spike_q} * 20'd15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jerk_q   <= JERK_RST;
			hyst_q   <= HYST_RST;
			tol_q    <= TOL_RST;
			slim_q   <= SPEED_RST;
			active_q <= 1'b0;
			seen_q   <= 1'b0;
			last_q   <= '0;
			total_q  <= '0;
			hold_q   <= '0;
			min_q    <= '0;
			max_q    <= '0;
			ext_q    <= '0;
			sum_q    <= '0;
			prev_q   <= '0;
			spike_q  <= '0;
			flex_q   <= '0;
			phase_q  <= PH_NEUTRAL;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_JERK: jerk_q <= cfg_data;
					CFG_HYST: hyst_q <= cfg_data[14:0];
					CFG_TOL:  tol_q  <= cfg_data[14:0];
					default:  slim_q <= cfg_data[15:0];
				endcase
			end
			if (cmd.update) begin
				if (kind_q == KIND_START) begin
					active_q <= 1'b1;
					last_q   <= ts_q;
					seen_q   <= 1'b0;
					total_q  <= '0;
					hold_q   <= '0;
					min_q    <= '0;
					max_q    <= '0;
					ext_q    <= '0;
					sum_q    <= '0;
					prev_q   <= '0;
					spike_q  <= '0;
					flex_q   <= '0;
					phase_q  <= PH_NEUTRAL;
				end else if (kind_q == KIND_STOP) begin
					active_q <= 1'b0;
				end else if (take) begin
					last_q  <= ts_q;
					seen_q  <= 1'b1;
					min_q   <= min_n;
					max_q   <= max_n;
					sum_q   <= sum_n;
					total_q <= total_n;
					prev_q  <= root_q;
					spike_q <= spike_n;
					ext_q   <= ext_n;
					phase_q <= phase_n;
					flex_q  <= flex_n;
					hold_q  <= hold_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			ts_q    <= timestamp_ms;
			fresh_q <= sample_fresh;
			ang_q   <= roll_angle;
			rx_q    <= rate_x;
			ry_q    <= rate_y;
			rz_q    <= rate_z;
		end
		if (cmd.sq_acc) acc_q <= cmd.sq_first ? sq : acc_q + sq;
		if (cmd.root_init) begin
			rad_q  <= acc_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			rem_q  <= r_ge ? r_diff[16:0] : r_sh[16:0];
			root_q <= {root_q[14:0], r_ge};
		end
		if (cmd.mul_lo) plo_q <= jerk_q * dt[15:0];
		if (cmd.mul_hi) prod_q <= {16'd0, plo_q} + {phi, 16'd0};
		if (cmd.update) taken_q <= take;
		if (cmd.div_init) begin
			divq_q <= sum_q;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			drem_q <= d_ge ? d_diff[31:0] : d_sh[31:0];
			divq_q <= {divq_q[SUM_WIDTH-2:0], d_ge};
		end
		if (cmd.out_load) begin
			session_on        <= active_q;
			sample_taken      <= taken_q;
			angle_min         <= mn;
			angle_max         <= mx;
			amplitude         <= 15'(mx - mn);
			if (total_q == '0) mean_speed <= '0;
			else if (|divq_q[SUM_WIDTH-1:16]) mean_speed <= 16'hFFFF;
			else mean_speed <= divq_q[15:0];
			smoothness_tenths <= (s15 >= 20'd1000) ? 10'd0 : 10'(20'd1000 - s15);
			flexion_total     <= flex_q;
			tremor_total      <= spike_q;
			holding_ms        <= hold_q;
		end
	end

endmodule

// ===== rtl/motion_session_analytics.sv =====
// Top level of the motion session statistics block.
// Depends on msa_pkg, msa_ctrl and msa_dp.
//
// Input channel: in_valid/in_stall carry one beat per item (start session,
// stop session or motion sample). Output channel: out_valid/out_stall carry
// one statistics snapshot beat per input beat, in order.
// Each item is worked in steps after acceptance: three squarings through
// one 16x16 multiplier, one setup and sixteen steps of the bit-pair square
// root, the 24x32 threshold product computed in two halves, an update,
// then one setup and 48 steps of the restoring divider for the mean speed,
// and a load of the result register. The divider takes the most steps.
// A new item is taken once the previous one has reached the result register,
// so the block works on one item at a time.
// When the receiver stalls, the snapshot holds in the result register and the
// next item is still accepted and worked; it waits at the end until the
// register frees up.
// Reset clears the session and all statistics and loads the register
// defaults; configuration writes go through cfg_we/cfg_index/cfg_data and
// are meant only while the block is idle.
module motion_session_analytics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] timestamp_ms,
	input  logic        sample_fresh,
	input  logic [14:0] roll_angle,
	input  logic [15:0] rate_x,
	input  logic [15:0] rate_y,
	input  logic [15:0] rate_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        session_on,
	output logic        sample_taken,
	output logic [14:0] angle_min,
	output logic [14:0] angle_max,
	output logic [14:0] amplitude,
	output logic [15:0] mean_speed,
	output logic [9:0]  smoothness_tenths,
	output logic [15:0] flexion_total,
	output logic [15:0] tremor_total,
	output logic [31:0] holding_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import msa_pkg::*;

	// step commands from the sequencer to the datapath
	msa_cmd_t cmd;

	// sequencer: handshakes, step counting, result register valid
	msa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath: capture, arithmetic units, session state, snapshot
	msa_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.kind              (kind),
		.timestamp_ms      (timestamp_ms),
		.sample_fresh      (sample_fresh),
		.roll_angle        (roll_angle),
		.rate_x            (rate_x),
		.rate_y            (rate_y),
		.rate_z            (rate_z),
		.session_on        (session_on),
		.sample_taken      (sample_taken),
		.angle_min         (angle_min),
		.angle_max         (angle_max),
		.amplitude         (amplitude),
		.mean_speed        (mean_speed),
		.smoothness_tenths (smoothness_tenths),
		.flexion_total     (flexion_total),
		.tremor_total      (tremor_total),
		.holding_ms        (holding_ms)
	);

endmodule
